// ===== sv/xtea_block_cipher_unit_defines.svh =====
// assertion macros shared by the xtea checker
`ifndef XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// property that must hold in the cycle after the antecedent
`define XTEA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xtea checker: next-cycle property failed");

// property that must hold in the same cycle as the antecedent
`define XTEA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xtea checker: same-cycle property failed");

`endif

// ===== sv/xtea_pkg.sv =====
// shared constants, types and codes of the xtea cipher unit
package xtea_pkg;

	localparam int WORD_W     = 32;
	localparam int DIGIT_W    = 8;
	localparam int NUM_DIGITS = WORD_W / DIGIT_W;
	localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
	localparam int ROUND_W    = 8;
	localparam int KEY_WORDS  = 4;
	localparam int CFG_IDX_W  = 3;

	localparam logic [WORD_W-1:0] DELTA     = 32'h9E37_79B9;
	// two's complement of delta, so sum - delta is an add
	localparam logic [WORD_W-1:0] NEG_DELTA = 32'h61C8_8647;

	localparam logic [ROUND_W-1:0] ROUNDS_RESET = 8'd32;

	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROUND_COUNT = 3'd0,
		REG_KEY0        = 3'd1,
		REG_KEY1        = 3'd2,
		REG_KEY2        = 3'd3,
		REG_KEY3        = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	typedef struct packed {
		logic                 load;
		logic                 step;
		logic                 phase;
		logic [DIG_IDX_W-1:0] digit;
		logic                 last_digit;
	} ctrl_t;

endpackage

// ===== sv/xtea_ctrl.sv =====
// sequencer: digit, half-round and round counters of the serial datapath
module xtea_ctrl
	import xtea_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ROUND_W-1:0] round_count,
	input  logic               res_free,
	output ctrl_t              ctrl,
	output logic               busy,
	output logic               done
);

	state_t               state_q, state_d;
	logic [DIG_IDX_W-1:0] digit_q, digit_d;
	logic                 phase_q, phase_d;
	logic [ROUND_W-1:0]   rounds_q, rounds_d;
	logic                 last_digit;

	assign last_digit = (digit_q == DIG_IDX_W'(NUM_DIGITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			digit_q  <= '0;
			phase_q  <= 1'b0;
			rounds_q <= '0;
		end else begin
			state_q  <= state_d;
			digit_q  <= digit_d;
			phase_q  <= phase_d;
			rounds_q <= rounds_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		digit_d         = digit_q;
		phase_d         = phase_q;
		rounds_d        = rounds_q;
		busy            = 1'b1;
		done            = 1'b0;
		ctrl.load       = 1'b0;
		ctrl.step       = 1'b0;
		ctrl.phase      = phase_q;
		ctrl.digit      = digit_q;
		ctrl.last_digit = last_digit;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.load = 1'b1;
					digit_d   = '0;
					phase_d   = 1'b0;
					rounds_d  = round_count;
					state_d   = (round_count == '0) ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.step = 1'b1;
				digit_d   = digit_q + DIG_IDX_W'(1);
				if (last_digit) begin
					phase_d = ~phase_q;
					// a round ends after the second half-round
					if (phase_q) begin
						rounds_d = rounds_q - ROUND_W'(1);
						if (rounds_q == ROUND_W'(1)) begin
							state_d = ST_DONE;
						end
					end
				end
			end
			ST_DONE: begin
				done = 1'b1;
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/xtea_dp.sv =====
// digit-serial xtea datapath: word, sum and carry registers, one byte per cycle
module xtea_dp
	import xtea_pkg::*;
(
	input  logic               clk,
	input  ctrl_t              ctrl,
	input  logic               cmd,
	input  logic [WORD_W-1:0]  block_high,
	input  logic [WORD_W-1:0]  block_low,
	input  key_t               key,
	input  logic [ROUND_W-1:0] round_count,
	output logic [WORD_W-1:0]  v0,
	output logic [WORD_W-1:0]  v1
);

	logic [WORD_W-1:0]  v0_q, v1_q, sum_q, sumn_q;
	logic               dec_q;
	logic               cmix_q, csk_q, cacc_q, csum_q;

	logic               tgt_is_v1;
	logic               first;
	logic [WORD_W-1:0]  src, tgt, shl, shr, kw, dlt, sumn_next;
	logic [1:0]         ksel;
	logic [DIGIT_W-1:0] src_d, mixa_d, sum_d, key_d, dlt_d, f_d, fop_d;
	logic [DIGIT_W:0]   mix_s, sk_s, acc_s, sn_s;
	logic               cmix_in, csk_in, cacc_in, csum_in;

	// which word is updated in this half-round; decipher runs the halves swapped
	assign tgt_is_v1 = ctrl.phase ^ dec_q;
	assign src  = tgt_is_v1 ? v0_q : v1_q;
	assign tgt  = tgt_is_v1 ? v1_q : v0_q;
	assign ksel = tgt_is_v1 ? sum_q[12:11] : sum_q[1:0];
	assign kw   = key[ksel];
	assign shl  = src << 4;
	assign shr  = src >> 5;
	assign dlt  = dec_q ? NEG_DELTA : DELTA;

	assign first   = (ctrl.digit == '0);
	assign cmix_in = first ? 1'b0 : cmix_q;
	assign csk_in  = first ? 1'b0 : csk_q;
	assign cacc_in = first ? dec_q : cacc_q;
	assign csum_in = first ? 1'b0 : csum_q;

	// source, sum and key stay put during a half-round and are read by digit
	assign src_d  = src[ctrl.digit*DIGIT_W +: DIGIT_W];
	assign mixa_d = shl[ctrl.digit*DIGIT_W +: DIGIT_W] ^ shr[ctrl.digit*DIGIT_W +: DIGIT_W];
	assign sum_d  = sum_q[ctrl.digit*DIGIT_W +: DIGIT_W];
	assign key_d  = kw[ctrl.digit*DIGIT_W +: DIGIT_W];
	assign dlt_d  = dlt[ctrl.digit*DIGIT_W +: DIGIT_W];

	assign mix_s = {1'b0, mixa_d} + {1'b0, src_d} + {{DIGIT_W{1'b0}}, cmix_in};
	assign sk_s  = {1'b0, sum_d} + {1'b0, key_d} + {{DIGIT_W{1'b0}}, csk_in};
	assign f_d   = mix_s[DIGIT_W-1:0] ^ sk_s[DIGIT_W-1:0];
	// subtract as add of the complement with carry-in set on the first digit
	assign fop_d = dec_q ? ~f_d : f_d;
	assign acc_s = {1'b0, tgt[DIGIT_W-1:0]} + {1'b0, fop_d} + {{DIGIT_W{1'b0}}, cacc_in};
	assign sn_s  = {1'b0, sum_d} + {1'b0, dlt_d} + {{DIGIT_W{1'b0}}, csum_in};

	assign sumn_next = {sn_s[DIGIT_W-1:0], sumn_q[WORD_W-1:DIGIT_W]};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v0_q  <= block_high;
			v1_q  <= block_low;
			dec_q <= cmd;
			sum_q <= (cmd == CMD_DEC) ? DELTA * WORD_W'(round_count) : '0;
		end else if (ctrl.step) begin
			// target word rotates right, new digit enters at the top
			if (tgt_is_v1) begin
				v1_q <= {acc_s[DIGIT_W-1:0], v1_q[WORD_W-1:DIGIT_W]};
			end else begin
				v0_q <= {acc_s[DIGIT_W-1:0], v0_q[WORD_W-1:DIGIT_W]};
			end
			cmix_q <= mix_s[DIGIT_W];
			csk_q  <= sk_s[DIGIT_W];
			cacc_q <= acc_s[DIGIT_W];
			// next sum is built serially during the first half-round
			if (!ctrl.phase) begin
				sumn_q <= sumn_next;
				csum_q <= sn_s[DIGIT_W];
				if (ctrl.last_digit) begin
					sum_q <= sumn_next;
				end
			end
		end
	end

	assign v0 = v0_q;
	assign v1 = v1_q;

endmodule

// ===== sv/xtea_block_cipher_unit.sv =====
// top level of the xtea block cipher unit: config registers, handshakes, result register
// one block at a time: a new block is taken only after the result register has taken the last result
// the run time is set by the byte-wide serial adders: four digits per half-round
// zero rounds: the block goes to the result register unchanged
// reset: round_count 32, key 0, no result pending; asynchronous, active low
module xtea_block_cipher_unit
	import xtea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 blk_valid,
	output logic                 blk_stall,
	input  logic                 cmd,
	input  logic [WORD_W-1:0]    block_high,
	input  logic [WORD_W-1:0]    block_low,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [WORD_W-1:0]    result_high,
	output logic [WORD_W-1:0]    result_low
);

	logic [ROUND_W-1:0] round_count_q;
	key_t               key_q;
	logic               res_valid_q;
	logic [WORD_W-1:0]  result_high_q, result_low_q;

	ctrl_t              ctrl;
	logic               busy, done, start, res_free, res_load;
	logic [WORD_W-1:0]  v0, v1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= ROUNDS_RESET;
			key_q         <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROUND_COUNT: round_count_q <= cfg_data[ROUND_W-1:0];
				REG_KEY0:        key_q[0]      <= cfg_data;
				REG_KEY1:        key_q[1]      <= cfg_data;
				REG_KEY2:        key_q[2]      <= cfg_data;
				REG_KEY3:        key_q[3]      <= cfg_data;
				default:         ;
			endcase
		end
	end

	assign blk_stall = busy;
	assign start     = blk_valid && !blk_stall;
	// result register is free when empty or being taken this cycle
	assign res_free  = !res_valid_q || !res_stall;
	assign res_load  = done && res_free;

	xtea_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.round_count (round_count_q),
		.res_free    (res_free),
		.ctrl        (ctrl),
		.busy        (busy),
		.done        (done)
	);

	xtea_dp u_dp (
		.clk         (clk),
		.ctrl        (ctrl),
		.cmd         (cmd),
		.block_high  (block_high),
		.block_low   (block_low),
		.key         (key_q),
		.round_count (round_count_q),
		.v0          (v0),
		.v1          (v1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_high_q <= v0;
			result_low_q  <= v1;
		end
	end

	assign res_valid   = res_valid_q;
	assign result_high = result_high_q;
	assign result_low  = result_low_q;

endmodule

// ===== sv/xtea_chk.sv =====
// port-level checker for the xtea block cipher unit, with its bind
`include "xtea_block_cipher_unit_defines.svh"

module xtea_chk
	import xtea_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic                 blk_valid,
	input logic                 blk_stall,
	input logic                 res_valid,
	input logic                 res_stall,
	input logic [WORD_W-1:0]    result_high,
	input logic [WORD_W-1:0]    result_low
);

	// a waiting result keeps its value
	`XTEA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(result_high) && $stable(result_low))

	// one block at a time: the input side closes right after a transfer
	`XTEA_ASSERT_NEXT(a_busy_after_xfer, blk_valid && !blk_stall, blk_stall)

	// no new result can appear the cycle after an input transfer
	`XTEA_ASSERT_NEXT(a_no_instant_res, blk_valid && !blk_stall, !$rose(res_valid))

	// config writes are never held off
	`XTEA_ASSERT_SAME(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind xtea_block_cipher_unit xtea_chk u_xtea_chk (.*);
